// File: src/bwts_pkg.sv
`default_nettype none

package bwts_pkg;

    localparam int FRAC_W      = 16;
    localparam int DIM_CFG_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int TEXEL_W     = 24;
    localparam int NUM_TAPS    = 4;
    localparam int NUM_CH      = 3;
    localparam int WT_W        = 17;
    localparam int PROD_W      = 25;
    localparam int OUT_W       = 16;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 48;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;

    typedef struct packed {
        logic valid;
        logic sample;
    } t_ctl;

endpackage

`default_nettype wire

// File: src/bwts_addr.sv
`default_nettype none

module bwts_addr #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256,
    parameter int RW       = $clog2(MAX_ROWS),
    parameter int CW       = $clog2(MAX_COLS),
    parameter int AW       = $clog2(MAX_ROWS * MAX_COLS)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  wire                                  i_action,
    input  wire  [bwts_pkg::IN_DATA_W-1:0]       i_data,
    input  wire  [bwts_pkg::DIM_CFG_W-1:0]       i_height,
    input  wire  [bwts_pkg::DIM_CFG_W-1:0]       i_width,
    output bwts_pkg::t_ctl                       o_ctl,
    output logic [AW-1:0]                        o_rd_addr [bwts_pkg::NUM_TAPS],
    output logic                                 o_wr_ok,
    output logic [AW-1:0]                        o_wr_addr,
    output logic [bwts_pkg::TEXEL_W-1:0]         o_wr_data,
    output logic [7:0]                           o_fu,
    output logic [7:0]                           o_fv
);

    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int WW = $clog2(MAX_COLS + 1);

    logic [HW-1:0] h;
    logic [WW-1:0] w;

    bwts_pkg::t_ctl                    r_a_ctl;
    logic [7:0]                        r_a_row;
    logic [7:0]                        r_a_col;
    logic [bwts_pkg::TEXEL_W-1:0]      r_a_rgb;
    logic [bwts_pkg::FRAC_W-1:0]       r_a_u;
    logic [bwts_pkg::FRAC_W-1:0]       r_a_v;

    bwts_pkg::t_ctl                    r_b_ctl;
    logic [bwts_pkg::FRAC_W+HW-1:0]    r_b_us;
    logic [bwts_pkg::FRAC_W+WW-1:0]    r_b_vs;
    logic                              r_b_wr_ok;
    logic [AW-1:0]                     r_b_wr_addr;
    logic [bwts_pkg::TEXEL_W-1:0]      r_b_rgb;

    logic [RW-1:0] r0, r1;
    logic [CW-1:0] c0, c1;
    logic [HW-1:0] r0p1;
    logic [WW-1:0] c0p1;

    // dimension clamp: zero means one, oversize saturates
    always_comb begin
        if (i_height == '0) begin
            h = HW'(1);
        end else if (32'(i_height) > MAX_ROWS) begin
            h = HW'(MAX_ROWS);
        end else begin
            h = HW'(i_height);
        end
        if (i_width == '0) begin
            w = WW'(1);
        end else if (32'(i_width) > MAX_COLS) begin
            w = WW'(MAX_COLS);
        end else begin
            w = WW'(i_width);
        end
    end

    // stage a: input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl.valid  <= i_valid;
            r_a_ctl.sample <= (i_action == bwts_pkg::ACT_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_row <= i_data[7:0];
            r_a_col <= i_data[15:8];
            r_a_rgb <= {i_data[23:16], i_data[31:24], i_data[39:32]};
            r_a_u   <= i_data[55:40];
            r_a_v   <= i_data[71:56];
        end
    end

    // stage b: scale coordinates, form write address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_us      <= (bwts_pkg::FRAC_W+HW)'(r_a_u) * (bwts_pkg::FRAC_W+HW)'(h);
            r_b_vs      <= (bwts_pkg::FRAC_W+WW)'(r_a_v) * (bwts_pkg::FRAC_W+WW)'(w);
            r_b_wr_ok   <= (32'(r_a_row) < MAX_ROWS) && (32'(r_a_col) < MAX_COLS);
            r_b_wr_addr <= AW'(RW'(r_a_row)) * AW'(MAX_COLS) + AW'(CW'(r_a_col));
            r_b_rgb     <= r_a_rgb;
        end
    end

    // wrap neighbors and tap addresses
    always_comb begin
        r0   = r_b_us[bwts_pkg::FRAC_W +: RW];
        c0   = r_b_vs[bwts_pkg::FRAC_W +: CW];
        r0p1 = HW'(r0) + HW'(1);
        c0p1 = WW'(c0) + WW'(1);
        r1   = (r0p1 >= h) ? '0 : r0p1[RW-1:0];
        c1   = (c0p1 >= w) ? '0 : c0p1[CW-1:0];
        o_rd_addr[0] = AW'(r0) * AW'(MAX_COLS) + AW'(c0);
        o_rd_addr[1] = AW'(r0) * AW'(MAX_COLS) + AW'(c1);
        o_rd_addr[2] = AW'(r1) * AW'(MAX_COLS) + AW'(c0);
        o_rd_addr[3] = AW'(r1) * AW'(MAX_COLS) + AW'(c1);
    end

    assign o_ctl     = r_b_ctl;
    assign o_wr_ok   = r_b_wr_ok;
    assign o_wr_addr = r_b_wr_addr;
    assign o_wr_data = r_b_rgb;
    assign o_fu      = r_b_us[15:8];
    assign o_fv      = r_b_vs[15:8];

endmodule

`default_nettype wire

// File: src/bwts_mem.sv
`default_nettype none

module bwts_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire bwts_pkg::t_ctl                  i_ctl,
    input  wire  [AW-1:0]                        i_rd_addr [bwts_pkg::NUM_TAPS],
    input  wire                                  i_wr_ok,
    input  wire  [AW-1:0]                        i_wr_addr,
    input  wire  [bwts_pkg::TEXEL_W-1:0]         i_wr_data,
    input  wire  [7:0]                           i_fu,
    input  wire  [7:0]                           i_fv,
    output bwts_pkg::t_ctl                       o_ctl,
    output logic [bwts_pkg::TEXEL_W-1:0]         o_texel [bwts_pkg::NUM_TAPS],
    output logic [bwts_pkg::WT_W-1:0]            o_wt [bwts_pkg::NUM_TAPS]
);

    logic           wr_en;
    logic [8:0]     fu_n, fv_n, fu_w, fv_w;
    bwts_pkg::t_ctl r_ctl;

    // one copy per tap, all written together
    assign wr_en = i_en && i_ctl.valid && !i_ctl.sample && i_wr_ok;

    for (genvar k = 0; k < bwts_pkg::NUM_TAPS; k++) begin : g_bank
        logic [bwts_pkg::TEXEL_W-1:0] r_mem [DEPTH];
        logic [bwts_pkg::TEXEL_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
            if (i_en) begin
                r_rd <= r_mem[i_rd_addr[k]];
            end
        end

        assign o_texel[k] = r_rd;
    end

    assign fu_w = {1'b0, i_fu};
    assign fv_w = {1'b0, i_fv};
    assign fu_n = 9'd256 - fu_w;
    assign fv_n = 9'd256 - fv_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_wt[0] <= bwts_pkg::WT_W'(fu_n) * bwts_pkg::WT_W'(fv_n);
            o_wt[1] <= bwts_pkg::WT_W'(fu_n) * bwts_pkg::WT_W'(fv_w);
            o_wt[2] <= bwts_pkg::WT_W'(fu_w) * bwts_pkg::WT_W'(fv_n);
            o_wt[3] <= bwts_pkg::WT_W'(fu_w) * bwts_pkg::WT_W'(fv_w);
        end
    end

    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

// File: src/bwts_blend.sv
`default_nettype none

module bwts_blend (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire bwts_pkg::t_ctl                  i_ctl,
    input  wire  [bwts_pkg::TEXEL_W-1:0]         i_texel [bwts_pkg::NUM_TAPS],
    input  wire  [bwts_pkg::WT_W-1:0]            i_wt [bwts_pkg::NUM_TAPS],
    output logic                                 o_valid,
    output logic [bwts_pkg::OUT_DATA_W-1:0]      o_data
);

    bwts_pkg::t_ctl              r_d_ctl;
    logic [bwts_pkg::PROD_W-1:0] r_prod [bwts_pkg::NUM_CH][bwts_pkg::NUM_TAPS];
    logic                        r_valid;
    logic [bwts_pkg::OUT_W-1:0]  r_out [bwts_pkg::NUM_CH];
    logic [bwts_pkg::PROD_W-1:0] acc [bwts_pkg::NUM_CH];

    // stage d: per channel, per tap products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else if (i_en) begin
            r_d_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < bwts_pkg::NUM_CH; ch++) begin
                for (int k = 0; k < bwts_pkg::NUM_TAPS; k++) begin
                    r_prod[ch][k] <=
                        bwts_pkg::PROD_W'(i_texel[k][16 - 8 * ch +: 8])
                        * bwts_pkg::PROD_W'(i_wt[k]);
                end
            end
        end
    end

    // stage e: sum and drop eight fraction bits
    always_comb begin
        for (int ch = 0; ch < bwts_pkg::NUM_CH; ch++) begin
            acc[ch] = r_prod[ch][0] + r_prod[ch][1] + r_prod[ch][2] + r_prod[ch][3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_d_ctl.valid && r_d_ctl.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < bwts_pkg::NUM_CH; ch++) begin
                r_out[ch] <= acc[ch][8 +: bwts_pkg::OUT_W];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_out[2], r_out[1], r_out[0]};

endmodule

`default_nettype wire

// File: src/bilinear_wrap_texture_sampler.sv
// a sample word reaches m_axis through registered stages a, b, c, d and e, in that order
// throughput: one word per cycle while the output word does not wait, writes and samples freely mixed
// the four taps read four copies of the texture, all written by every texel write
// reset: config back to 256 by 256, pipeline emptied; texture contents undefined
`default_nettype none

module bilinear_wrap_texture_sampler #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // config write channel
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [bwts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [bwts_pkg::DIM_CFG_W-1:0]       cfg_data,
    // input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // texel_row, texel_col, red_in, green_in, blue_in, u_frac, v_frac
    input  wire  [bwts_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // action
    input  wire                                  s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // red_out, green_out, blue_out
    output logic [bwts_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [bwts_pkg::DIM_CFG_W-1:0] r_height;
    logic [bwts_pkg::DIM_CFG_W-1:0] r_width;

    // whole pipeline moves together; it only halts when the output word waits
    logic en;

    bwts_pkg::t_ctl                ab_ctl;
    logic [AW-1:0]                 rd_addr [bwts_pkg::NUM_TAPS];
    logic                          wr_ok;
    logic [AW-1:0]                 wr_addr;
    logic [bwts_pkg::TEXEL_W-1:0]  wr_data;
    logic [7:0]                    fu, fv;

    bwts_pkg::t_ctl                mb_ctl;
    logic [bwts_pkg::TEXEL_W-1:0]  texel [bwts_pkg::NUM_TAPS];
    logic [bwts_pkg::WT_W-1:0]     wt [bwts_pkg::NUM_TAPS];

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // config registers, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 9'd256;
            r_width  <= 9'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bwts_pkg::REG_HEIGHT: begin
                    r_height <= cfg_data;
                end
                bwts_pkg::REG_WIDTH: begin
                    r_width <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // stages a and b: capture, scale, wrap, addresses
    bwts_addr #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s_axis_tvalid),
        .i_action  (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .i_height  (r_height),
        .i_width   (r_width),
        .o_ctl     (ab_ctl),
        .o_rd_addr (rd_addr),
        .o_wr_ok   (wr_ok),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_fu      (fu),
        .o_fv      (fv)
    );

    // stage c: texel reads and writes in order, weights
    bwts_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_ctl     (ab_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_ok   (wr_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_fu      (fu),
        .i_fv      (fv),
        .o_ctl     (mb_ctl),
        .o_texel   (texel),
        .o_wt      (wt)
    );

    // stages d and e: products, sums, output register
    bwts_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (mb_ctl),
        .i_texel (texel),
        .i_wt    (wt),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: tb/tb_bilinear_wrap_texture_sampler.sv
`default_nettype none

module tb_bilinear_wrap_texture_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS      = 256;
    localparam int NCOLS      = 256;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 12;

    // one directed row: a texel write or a sample, with an optional typed-in answer
    typedef struct {
        logic                            act;
        logic [7:0]                      row;
        logic [7:0]                      col;
        logic [7:0]                      red;
        logic [7:0]                      grn;
        logic [7:0]                      blu;
        logic [bwts_pkg::FRAC_W-1:0]     u;
        logic [bwts_pkg::FRAC_W-1:0]     v;
        bit                              known;
        logic [bwts_pkg::OUT_DATA_W-1:0] answer;
    } t_row;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [bwts_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [bwts_pkg::DIM_CFG_W-1:0]       cfg_data;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [bwts_pkg::IN_DATA_W-1:0]       s_axis_tdata;
    logic                                 s_axis_tuser;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic [bwts_pkg::OUT_DATA_W-1:0]      m_axis_tdata;

    bilinear_wrap_texture_sampler #(
        .MAX_ROWS(NROWS),
        .MAX_COLS(NCOLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the texture and of the two dimension registers
    logic [bwts_pkg::TEXEL_W-1:0]    texture [NROWS*NCOLS];
    bit                              stored  [NROWS*NCOLS];
    logic [bwts_pkg::DIM_CFG_W-1:0]  height_reg;
    logic [bwts_pkg::DIM_CFG_W-1:0]  width_reg;

    logic [bwts_pkg::OUT_DATA_W-1:0] pending_colors[$];

    int  mismatches;
    int  n_writes;
    int  n_samples;
    int  n_colors;
    int  n_cfg;
    int  idle_cycles;
    bit  calm;          // when set, no gaps and no stalls

    // zero reads as one row, anything past the texture saturates
    function automatic int unsigned dim_used(logic [bwts_pkg::DIM_CFG_W-1:0] d,
                                             int unsigned lim);
        if (d == 0)
            return 1;
        if (d > lim)
            return lim;
        return d;
    endfunction

    // row/column pair and 8-bit weights for one coordinate
    function automatic void split_coord(logic [bwts_pkg::FRAC_W-1:0] f, int unsigned n,
                                        output int unsigned i0, output int unsigned i1,
                                        output int unsigned frac);
        logic [31:0] scaled;
        scaled = f * n;
        i0     = scaled[31:16];
        frac   = scaled[15:8];
        i1     = (i0 + 1 >= n) ? 0 : i0 + 1;
    endfunction

    function automatic logic [bwts_pkg::OUT_DATA_W-1:0] filter_color(
            logic [bwts_pkg::FRAC_W-1:0] u, logic [bwts_pkg::FRAC_W-1:0] v);
        int unsigned r0, r1, c0, c1, fu, fv;
        logic [bwts_pkg::TEXEL_W-1:0] tap [bwts_pkg::NUM_TAPS];
        int unsigned wt [bwts_pkg::NUM_TAPS];
        logic [31:0] acc;
        logic [bwts_pkg::OUT_DATA_W-1:0] color;
        split_coord(u, dim_used(height_reg, NROWS), r0, r1, fu);
        split_coord(v, dim_used(width_reg, NCOLS), c0, c1, fv);
        tap[0] = texture[r0*NCOLS + c0];
        tap[1] = texture[r0*NCOLS + c1];
        tap[2] = texture[r1*NCOLS + c0];
        tap[3] = texture[r1*NCOLS + c1];
        wt[0]  = (256 - fu) * (256 - fv);
        wt[1]  = (256 - fu) * fv;
        wt[2]  = fu * (256 - fv);
        wt[3]  = fu * fv;
        // red sits in the top byte of a texel, lowest field of the result
        for (int ch = 0; ch < bwts_pkg::NUM_CH; ch++) begin
            acc = 0;
            for (int k = 0; k < bwts_pkg::NUM_TAPS; k++)
                acc += ((tap[k] >> (16 - 8*ch)) & 8'hFF) * wt[k];
            color[ch*bwts_pkg::OUT_W +: bwts_pkg::OUT_W] = acc[23:8];
        end
        return color;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // input side driver, updates the shadow on acceptance
    // ---------------------------------------------------------------
    task automatic send_word(logic act, logic [7:0] row, logic [7:0] col,
                             logic [7:0] red, logic [7:0] grn, logic [7:0] blu,
                             logic [bwts_pkg::FRAC_W-1:0] u,
                             logic [bwts_pkg::FRAC_W-1:0] v,
                             bit known, logic [bwts_pkg::OUT_DATA_W-1:0] answer);
        int gap;
        logic [bwts_pkg::OUT_DATA_W-1:0] color;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {v, u, blu, grn, red, col, row};
        s_axis_tuser  = act;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (act == bwts_pkg::ACT_WRITE) begin
            texture[row*NCOLS + col] = {red, grn, blu};
            stored[row*NCOLS + col]  = 1'b1;
            n_writes++;
        end else begin
            color = filter_color(u, v);
            // directed rows with a typed-in answer also guard the predictor
            if (known && color !== answer) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("predictor disagrees with table: u=%h v=%h table=%h calc=%h",
                             u, v, answer, color);
            end
            pending_colors.push_back(color);
            n_samples++;
        end
        @(negedge i_clk);
    endtask

    // never sample a texel that was not written: fill missing taps first
    task automatic fill_taps(logic [bwts_pkg::FRAC_W-1:0] u,
                             logic [bwts_pkg::FRAC_W-1:0] v);
        int unsigned r0, r1, c0, c1, fu, fv;
        int unsigned rs [bwts_pkg::NUM_TAPS];
        int unsigned cs [bwts_pkg::NUM_TAPS];
        split_coord(u, dim_used(height_reg, NROWS), r0, r1, fu);
        split_coord(v, dim_used(width_reg, NCOLS), c0, c1, fv);
        rs = '{r0, r0, r1, r1};
        cs = '{c0, c1, c0, c1};
        for (int k = 0; k < bwts_pkg::NUM_TAPS; k++)
            if (!stored[rs[k]*NCOLS + cs[k]])
                send_word(bwts_pkg::ACT_WRITE, rs[k], cs[k], $urandom, $urandom,
                          $urandom, $urandom, $urandom, 1'b0, '0);
    endtask

    task automatic sample_at(logic [bwts_pkg::FRAC_W-1:0] u,
                             logic [bwts_pkg::FRAC_W-1:0] v);
        fill_taps(u, v);
        send_word(bwts_pkg::ACT_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                  $urandom, u, v, 1'b0, '0);
    endtask

    // register writes only with the pipeline drained
    task automatic write_reg(logic [bwts_pkg::CFG_IDX_W-1:0] idx,
                             logic [bwts_pkg::DIM_CFG_W-1:0] val);
        s_axis_tvalid = 1'b0;
        while (pending_colors.size() != 0)
            @(negedge i_clk);
        // a trailing texel write produces no word, give it time to land
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == bwts_pkg::REG_HEIGHT)
            height_reg = val;
        else if (idx == bwts_pkg::REG_WIDTH)
            width_reg = val;
        n_cfg++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // result side: stalls and checking
    // ---------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        logic [bwts_pkg::OUT_DATA_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_colors++;
            if (pending_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color word %h", m_axis_tdata);
            end else begin
                want = pending_colors.pop_front();
                for (int ch = 0; ch < bwts_pkg::NUM_CH; ch++)
                    if (m_axis_tdata[ch*bwts_pkg::OUT_W +: bwts_pkg::OUT_W]
                            !== want[ch*bwts_pkg::OUT_W +: bwts_pkg::OUT_W]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("channel %0d: expected %h got %h", ch,
                                     want[ch*bwts_pkg::OUT_W +: bwts_pkg::OUT_W],
                                     m_axis_tdata[ch*bwts_pkg::OUT_W +: bwts_pkg::OUT_W]);
                    end
            end
        end
    end

    // watchdog on cycles with no accepted word anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d words still expected", pending_colors.size());
            $display("tb_bilinear_wrap_texture_sampler: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // directed table, then randomized phases over several texture sizes
    // ---------------------------------------------------------------
    t_row directed [] = '{
        // corner texels and their neighbours at full size, extremes of color
        '{bwts_pkg::ACT_WRITE,  8'd0,   8'd0,   8'hFF, 8'h00, 8'hFF, 16'h0000, 16'h0000,
          0, '0},
        '{bwts_pkg::ACT_WRITE,  8'd0,   8'd1,   8'h00, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF,
          0, '0},
        '{bwts_pkg::ACT_WRITE,  8'd1,   8'd0,   8'h80, 8'h7F, 8'h01, 16'h0000, 16'hFFFF,
          0, '0},
        '{bwts_pkg::ACT_WRITE,  8'd1,   8'd1,   8'h55, 8'hAA, 8'hFE, 16'hFFFF, 16'h0000,
          0, '0},
        '{bwts_pkg::ACT_WRITE,  8'd255, 8'd255, 8'h12, 8'h34, 8'h56, 16'h0000, 16'h0000,
          0, '0},
        '{bwts_pkg::ACT_WRITE,  8'd255, 8'd0,   8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
          0, '0},
        '{bwts_pkg::ACT_WRITE,  8'd0,   8'd255, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
          0, '0},
        // origin lands exactly on texel (0,0): byte scaled by 256
        '{bwts_pkg::ACT_SAMPLE, 8'hFF,  8'hFF,  8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000,
          1, {16'hFF00, 16'h0000, 16'hFF00}},
        // top of both fractions wraps to row 0 and column 0
        '{bwts_pkg::ACT_SAMPLE, 8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  16'hFFFF, 16'hFFFF,
          0, '0},
        '{bwts_pkg::ACT_SAMPLE, 8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  16'hFFFF, 16'h0000,
          0, '0},
        '{bwts_pkg::ACT_SAMPLE, 8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  16'h0000, 16'hFFFF,
          0, '0},
        // halfway between the first four texels
        '{bwts_pkg::ACT_SAMPLE, 8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  16'h0080, 16'h0080,
          0, '0},
        '{bwts_pkg::ACT_SAMPLE, 8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  16'h00FF, 16'h0001,
          0, '0},
        // overwrite of a written texel, then read it back exactly
        '{bwts_pkg::ACT_WRITE,  8'd0,   8'd0,   8'h01, 8'h80, 8'hFE, 16'h0000, 16'h0000,
          0, '0},
        '{bwts_pkg::ACT_SAMPLE, 8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  16'h0000, 16'h0000,
          1, {16'hFE00, 16'h8000, 16'h0100}}
    };

    // height, width per phase: reset size, one texel, thin strips, zero and
    // oversize values that clamp, odd sizes
    int phase_h [] = '{1, 2, 256, 0, 511, 5, 3, 256, 17};
    int phase_w [] = '{1, 256, 2, 300, 0, 7, 1, 256, 129};

    initial begin
        logic [bwts_pkg::FRAC_W-1:0] u, v;
        int roll;
        i_rst_n       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bwts_pkg::ACT_WRITE;
        height_reg    = 9'd256;
        width_reg     = 9'd256;
        mismatches    = 0;
        n_writes      = 0;
        n_samples     = 0;
        n_colors      = 0;
        n_cfg         = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        foreach (stored[k]) stored[k] = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows run at the reset size
        foreach (directed[k]) begin
            if (directed[k].act == bwts_pkg::ACT_SAMPLE)
                fill_taps(directed[k].u, directed[k].v);
            send_word(directed[k].act, directed[k].row, directed[k].col,
                      directed[k].red, directed[k].grn, directed[k].blu,
                      directed[k].u, directed[k].v, directed[k].known, directed[k].answer);
        end

        foreach (phase_h[p]) begin
            write_reg(bwts_pkg::REG_HEIGHT, phase_h[p]);
            write_reg(bwts_pkg::REG_WIDTH, phase_w[p]);
            // unlisted index must leave the size alone
            if (p % 3 == 0)
                write_reg(bwts_pkg::CFG_IDX_W'(2 + p % 2), $urandom);
            calm = (p % 4 == 2);
            for (int n = 0; n < 30; n++) begin
                roll = $urandom_range(0, 99);
                u = $urandom;
                v = $urandom;
                if (roll < 10) begin
                    u = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                end
                if (roll < 25)
                    // stray texel anywhere in the full texture
                    send_word(bwts_pkg::ACT_WRITE, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
                else
                    sample_at(u, v);
            end
        end
        s_axis_tvalid = 1'b0;

        while (pending_colors.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d texel writes, %0d samples, %0d color words, %0d register writes",
                 n_writes, n_samples, n_colors, n_cfg);
        $display("sizes from one texel to 256 by 256, with clamped zero and oversize values");
        if (mismatches == 0) begin
            $display("tb_bilinear_wrap_texture_sampler: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_bilinear_wrap_texture_sampler: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
